>>> design/lsm_pkg.sv
// shared types, codes and the control store of the lattice swap step
// used by lattice_swap_metropolis_step; depends on nothing
package lsm_pkg;

  localparam int LSM_EDGE = 16;
  localparam int PC_W = 5;
  localparam logic [15:0] BETA_RESET = 16'd256;

  typedef enum logic [1:0] {
    REQ_LOAD = 2'd0,
    REQ_READ = 2'd1,
    REQ_MOVE = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    SITE_VACANT = 2'd0,
    SITE_RED    = 2'd1,
    SITE_BLUE   = 2'd2
  } site_t;

  typedef enum logic [2:0] {
    ST_DONE = 3'd0,
    ST_ACC  = 3'd1,
    ST_REJ  = 3'd2,
    ST_VAC  = 3'd3,
    ST_SAME = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    DIR_UP    = 3'd0,
    DIR_DOWN  = 3'd1,
    DIR_LEFT  = 3'd2,
    DIR_RIGHT = 3'd3,
    DIR_FRONT = 3'd4,
    DIR_BACK  = 3'd5
  } dir_t;

  // memory address source of one step
  typedef enum logic [2:0] {
    A_SITE = 3'd0,
    A_NBR  = 3'd1,
    A_N0   = 3'd2,
    A_N1   = 3'd3,
    A_N2   = 3'd4,
    A_N3   = 3'd5,
    A_N4   = 3'd6,
    A_N5   = 3'd7
  } addr_sel_t;

  typedef enum logic [1:0] {
    W_LOAD = 2'd0,
    W_A    = 2'd1,
    W_B    = 2'd2
  } wsrc_t;

  typedef enum logic [3:0] {
    ACT_NONE     = 4'd0,
    ACT_CAP_LOAD = 4'd1,
    ACT_CAP_A    = 4'd2,
    ACT_CHECK    = 4'd3,
    ACT_COUNT    = 4'd4,
    ACT_E1       = 4'd5,
    ACT_CLR      = 4'd6,
    ACT_CHG      = 4'd7,
    ACT_MUL      = 4'd8,
    ACT_TEST     = 4'd9
  } act_t;

  typedef enum logic [1:0] {
    BR_NONE   = 2'd0,
    BR_ALWAYS = 2'd1,
    BR_SKIP   = 2'd2,
    BR_ACC    = 2'd3
  } br_t;

  typedef struct packed {
    addr_sel_t        addr;
    logic             rd;
    logic             wr;
    wsrc_t            wsrc;
    act_t             act;
    br_t              br;
    logic [PC_W-1:0]  target;
    logic             done;
  } ucode_t;

  localparam logic [PC_W-1:0] PC_LOAD = 5'd0;
  localparam logic [PC_W-1:0] PC_READ = 5'd1;
  localparam logic [PC_W-1:0] PC_MOVE = 5'd3;
  localparam logic [PC_W-1:0] PC_DONE = 5'd26;

  function automatic ucode_t uw(addr_sel_t addr, logic rd, logic wr, wsrc_t wsrc,
                                act_t act, br_t br, logic [PC_W-1:0] target);
    ucode_t w;
    w.addr   = addr;
    w.rd     = rd;
    w.wr     = wr;
    w.wsrc   = wsrc;
    w.act    = act;
    w.br     = br;
    w.target = target;
    w.done   = 1'b0;
    return w;
  endfunction

  // control store: read data lands in the step after the one that issues its read
  function automatic ucode_t ucode(logic [PC_W-1:0] pc);
    ucode_t w;
    w = uw(A_SITE, 1'b0, 1'b0, W_A, ACT_NONE, BR_NONE, PC_DONE);
    case (pc)
      5'd0:  w = uw(A_SITE, 1'b0, 1'b1, W_LOAD, ACT_CAP_LOAD, BR_ALWAYS, PC_DONE);
      5'd1:  w = uw(A_SITE, 1'b1, 1'b0, W_A, ACT_NONE,  BR_NONE,   PC_DONE);
      5'd2:  w = uw(A_SITE, 1'b0, 1'b0, W_A, ACT_CAP_A, BR_ALWAYS, PC_DONE);
      // move: fetch site and partner
      5'd3:  w = uw(A_SITE, 1'b1, 1'b0, W_A, ACT_NONE,  BR_NONE, PC_DONE);
      5'd4:  w = uw(A_NBR,  1'b1, 1'b0, W_A, ACT_CAP_A, BR_NONE, PC_DONE);
      5'd5:  w = uw(A_N0,   1'b1, 1'b0, W_A, ACT_CHECK, BR_SKIP, PC_DONE);
      // neighbor count before the swap
      5'd6:  w = uw(A_N1,   1'b1, 1'b0, W_A, ACT_COUNT, BR_NONE, PC_DONE);
      5'd7:  w = uw(A_N2,   1'b1, 1'b0, W_A, ACT_COUNT, BR_NONE, PC_DONE);
      5'd8:  w = uw(A_N3,   1'b1, 1'b0, W_A, ACT_COUNT, BR_NONE, PC_DONE);
      5'd9:  w = uw(A_N4,   1'b1, 1'b0, W_A, ACT_COUNT, BR_NONE, PC_DONE);
      5'd10: w = uw(A_N5,   1'b1, 1'b0, W_A, ACT_COUNT, BR_NONE, PC_DONE);
      5'd11: w = uw(A_SITE, 1'b0, 1'b0, W_A, ACT_COUNT, BR_NONE, PC_DONE);
      // swap
      5'd12: w = uw(A_SITE, 1'b0, 1'b1, W_B, ACT_E1,    BR_NONE, PC_DONE);
      5'd13: w = uw(A_NBR,  1'b0, 1'b1, W_A, ACT_CLR,   BR_NONE, PC_DONE);
      // neighbor count after the swap
      5'd14: w = uw(A_N0,   1'b1, 1'b0, W_A, ACT_NONE,  BR_NONE, PC_DONE);
      5'd15: w = uw(A_N1,   1'b1, 1'b0, W_A, ACT_COUNT, BR_NONE, PC_DONE);
      5'd16: w = uw(A_N2,   1'b1, 1'b0, W_A, ACT_COUNT, BR_NONE, PC_DONE);
      5'd17: w = uw(A_N3,   1'b1, 1'b0, W_A, ACT_COUNT, BR_NONE, PC_DONE);
      5'd18: w = uw(A_N4,   1'b1, 1'b0, W_A, ACT_COUNT, BR_NONE, PC_DONE);
      5'd19: w = uw(A_N5,   1'b1, 1'b0, W_A, ACT_COUNT, BR_NONE, PC_DONE);
      5'd20: w = uw(A_SITE, 1'b0, 1'b0, W_A, ACT_COUNT, BR_NONE, PC_DONE);
      5'd21: w = uw(A_SITE, 1'b0, 1'b0, W_A, ACT_CHG,   BR_NONE, PC_DONE);
      5'd22: w = uw(A_SITE, 1'b0, 1'b0, W_A, ACT_MUL,   BR_NONE, PC_DONE);
      5'd23: w = uw(A_SITE, 1'b0, 1'b0, W_A, ACT_TEST,  BR_ACC,  PC_DONE);
      // rejected: put both sites back
      5'd24: w = uw(A_SITE, 1'b0, 1'b1, W_A, ACT_NONE,  BR_NONE, PC_DONE);
      5'd25: w = uw(A_NBR,  1'b0, 1'b1, W_B, ACT_NONE,  BR_NONE, PC_DONE);
      default: w.done = 1'b1;
    endcase
    return w;
  endfunction

  // (target - occupied)^2, zero for a vacant site
  function automatic logic [4:0] site_energy(logic [1:0] v, logic [2:0] occ);
    logic [4:0] e;
    e = 5'd0;
    if (v == SITE_RED) begin
      case (occ)
        3'd0: e = 5'd9;
        3'd1: e = 5'd4;
        3'd2: e = 5'd1;
        3'd3: e = 5'd0;
        3'd4: e = 5'd1;
        3'd5: e = 5'd4;
        3'd6: e = 5'd9;
        default: e = 5'd16;
      endcase
    end else if (v != SITE_VACANT) begin
      case (occ)
        3'd0: e = 5'd25;
        3'd1: e = 5'd16;
        3'd2: e = 5'd9;
        3'd3: e = 5'd4;
        3'd4: e = 5'd1;
        3'd5: e = 5'd0;
        3'd6: e = 5'd1;
        default: e = 5'd4;
      endcase
    end
    return e;
  endfunction

endpackage

>>> design/lsm_if.sv
// request and result channels of the lattice swap step
// plain valid/ready interfaces; no dependencies
interface lsm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [3:0]  coord_i;
  logic [3:0]  coord_j;
  logic [3:0]  coord_k;
  logic [2:0]  direction;
  logic [15:0] neg_log_draw;
  logic [1:0]  load_value;

  modport source (
    output valid, req_type, coord_i, coord_j, coord_k, direction, neg_log_draw,
           load_value,
    input  ready
  );
  modport sink (
    input  valid, req_type, coord_i, coord_j, coord_k, direction, neg_log_draw,
           load_value,
    output ready
  );
endinterface

interface lsm_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] site_value;
  logic [2:0] status;
  logic [4:0] energy_change;

  modport source (
    output valid, site_value, status, energy_change,
    input  ready
  );
  modport sink (
    input  valid, site_value, status, energy_change,
    output ready
  );
endinterface

>>> design/lattice_swap_metropolis_step.sv
// lattice gas with metropolis swap moves, run by a small control store
// depends on lsm_pkg and the channel interfaces in lsm_if.sv
//
// usage: each word on req is a load, read or swap-move request for one site;
// each produces exactly one word on rsp with the site's content afterwards,
// a status and the absolute local energy change of an evaluated move.
// beta is set through cfg_wr_en / cfg_wr_data; the user must write it only
// while the block is idle, the block itself does not enforce this. one
// request is in work at a time; req.ready is high while the sequencer waits
// for a request. the next request is taken the cycle after the result is
// registered. the move time is set by the single memory port: two fetches,
// six neighbor reads before and six after the swap, two writes for the swap
// and two more to undo a rejected one.
// the result sits in an output register, so a stalled receiver only holds
// the sequencer at its final step when a second result is ready.
// reset (rst, synchronous) idles the sequencer, empties the output register
// and sets beta to 1.0; lattice contents are undefined until loaded.
module lattice_swap_metropolis_step
  import lsm_pkg::*;
#(
  parameter int EDGE = LSM_EDGE
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data,
  lsm_req_if.sink      req,
  lsm_rsp_if.source    rsp
);

  localparam int CW = $clog2(EDGE);
  localparam int AW = 3 * CW;
  localparam int SITE_DEPTH = 1 << AW;
  localparam logic [CW-1:0] EDGE_TOP = CW'(EDGE - 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } seq_state_t;

  function automatic int wrap_edge(int v);
    int r;
    r = v;
    for (int n = 0; n < 16; n++) begin
      if (r >= EDGE) r = r - EDGE;
    end
    return r;
  endfunction

  seq_state_t state, state_next;
  logic [PC_W-1:0] pc, pc_next;
  logic [15:0] beta;

  logic [CW-1:0] ci, cj, ck;
  dir_t dir_r;
  logic [15:0] draw;
  logic [1:0] load_v;

  logic [1:0] a, b, rd_data;
  logic [2:0] cnt;
  logic [4:0] e1, chg;
  logic [20:0] prod;
  status_t status;

  logic out_valid;
  logic [1:0] out_site;
  status_t out_status;
  logic [4:0] out_chg;

  logic [1:0] mem [SITE_DEPTH];

  logic [CW-1:0] coord_mod [16];
  logic [AW-1:0] nb [6];
  logic [AW-1:0] site_addr, addr;
  logic [1:0] wdata;
  logic [4:0] e2;
  ucode_t uc;
  logic accept, running, done_go, skip_now, accept_now, br_take;

  for (genvar g = 0; g < 16; g++) begin : g_mod
    assign coord_mod[g] = CW'(wrap_edge(g));
  end

  assign accept  = req.valid && req.ready;
  assign running = (state == S_RUN);
  assign uc      = ucode(pc);
  assign done_go = running && uc.done && (!out_valid || rsp.ready);

  assign skip_now   = (a == SITE_VACANT) || (a == rd_data);
  assign accept_now = {draw, 8'd0} >= {3'd0, prod};
  assign e2         = site_energy(b, cnt);

  // periodic neighbors of the addressed site
  always_comb begin
    site_addr = {ci, cj, ck};
    nb[DIR_UP]    = {(ci == '0) ? EDGE_TOP : ci - 1'b1, cj, ck};
    nb[DIR_DOWN]  = {(ci == EDGE_TOP) ? '0 : ci + 1'b1, cj, ck};
    nb[DIR_LEFT]  = {ci, (cj == '0) ? EDGE_TOP : cj - 1'b1, ck};
    nb[DIR_RIGHT] = {ci, (cj == EDGE_TOP) ? '0 : cj + 1'b1, ck};
    nb[DIR_FRONT] = {ci, cj, (ck == '0) ? EDGE_TOP : ck - 1'b1};
    nb[DIR_BACK]  = {ci, cj, (ck == EDGE_TOP) ? '0 : ck + 1'b1};
  end

  always_comb begin
    case (uc.addr)
      A_SITE: addr = site_addr;
      A_NBR: begin
        case (dir_r)
          DIR_UP:    addr = nb[DIR_UP];
          DIR_DOWN:  addr = nb[DIR_DOWN];
          DIR_LEFT:  addr = nb[DIR_LEFT];
          DIR_RIGHT: addr = nb[DIR_RIGHT];
          DIR_FRONT: addr = nb[DIR_FRONT];
          default:   addr = nb[DIR_BACK];
        endcase
      end
      A_N0:    addr = nb[DIR_UP];
      A_N1:    addr = nb[DIR_DOWN];
      A_N2:    addr = nb[DIR_LEFT];
      A_N3:    addr = nb[DIR_RIGHT];
      A_N4:    addr = nb[DIR_FRONT];
      default: addr = nb[DIR_BACK];
    endcase
  end

  always_comb begin
    case (uc.wsrc)
      W_LOAD:  wdata = load_v;
      W_A:     wdata = a;
      default: wdata = b;
    endcase
  end

  // sequencer
  always_comb begin
    case (uc.br)
      BR_ALWAYS: br_take = 1'b1;
      BR_SKIP:   br_take = skip_now;
      BR_ACC:    br_take = accept_now;
      default:   br_take = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    pc_next    = pc;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_RUN;
          case (req_t'(req.req_type))
            REQ_LOAD: pc_next = PC_LOAD;
            REQ_MOVE: pc_next = PC_MOVE;
            default:  pc_next = PC_READ;
          endcase
        end
      end
      S_RUN: begin
        if (uc.done) begin
          if (done_go) state_next = S_IDLE;
        end else if (br_take) begin
          pc_next = uc.target;
        end else begin
          pc_next = pc + 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= PC_LOAD;
      beta      <= BETA_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      if (cfg_wr_en) beta <= cfg_wr_data;
      if (done_go) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // lattice memory, one port
  always_ff @(posedge clk) begin
    if (running && uc.wr) mem[addr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (running && uc.rd) rd_data <= mem[addr];
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      ci     <= coord_mod[req.coord_i];
      cj     <= coord_mod[req.coord_j];
      ck     <= coord_mod[req.coord_k];
      dir_r  <= (req.direction >= 3'd6) ? dir_t'(req.direction - 3'd6)
                                        : dir_t'(req.direction);
      draw   <= req.neg_log_draw;
      load_v <= (req.load_value == 2'd3) ? SITE_BLUE : req.load_value;
      status <= ST_DONE;
      chg    <= 5'd0;
    end else if (running) begin
      case (uc.act)
        ACT_CAP_LOAD: a <= load_v;
        ACT_CAP_A:    a <= rd_data;
        ACT_CHECK: begin
          b   <= rd_data;
          cnt <= 3'd0;
          if (a == SITE_VACANT) begin
            status <= ST_VAC;
          end else if (a == rd_data) begin
            status <= ST_SAME;
          end
        end
        ACT_COUNT: cnt <= cnt + {2'd0, rd_data != SITE_VACANT};
        ACT_E1:    e1 <= site_energy(a, cnt);
        ACT_CLR:   cnt <= 3'd0;
        ACT_CHG:   chg <= (e2 > e1) ? e2 - e1 : e1 - e2;
        ACT_MUL:   prod <= beta * chg;
        ACT_TEST:  status <= accept_now ? ST_ACC : ST_REJ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (done_go) begin
      out_site   <= (status == ST_ACC) ? b : a;
      out_status <= status;
      out_chg    <= chg;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.site_value    = out_site;
  assign rsp.status        = out_status;
  assign rsp.energy_change = out_chg;

  a_accept_entry: assert property (@(posedge clk) disable iff (rst)
    accept |=> running && (pc == PC_LOAD || pc == PC_READ || pc == PC_MOVE))
    else $error("sequencer did not start at an entry point");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(done_go))
    else $error("result appeared without a final step");

  a_change_only_evaluated: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.energy_change != 5'd0 |->
      rsp.status == ST_ACC || rsp.status == ST_REJ)
    else $error("energy change reported for a request that was not evaluated");

  a_store_legal: assert property (@(posedge clk) disable iff (rst)
    running && uc.wr |-> wdata != 2'd3)
    else $error("illegal site code written to the lattice");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    running && !done_go |=> !accept)
    else $error("request taken while a move is in work");

endmodule
